// ----- src/bffa_pkg.sv -----
`timescale 1ns / 1ps

package bffa_pkg;

  // Pool geometry; BlockBytes must be a power of two of at least 2
  localparam int unsigned NumBlocks  = 256;
  localparam int unsigned BlockBytes = 4096;
  localparam int unsigned BlockShift = $clog2(BlockBytes);
  localparam int unsigned IdxW       = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned RunW       = $clog2(NumBlocks + 1);

  // Field widths
  localparam int unsigned AddrW    = 48;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned UsedW    = 21;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned NeedW    = SizeW + 1 - BlockShift;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 48;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_BASE_ADDRESS = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_TOTAL_SIZE   = CfgIdxW'(1);

  // Request codes
  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FIT    = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FREE_RD,
    ST_SWEEP,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic check;
    logic scan_step;
    logic free_read;
    logic sweep_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic alloc;
    logic need_bad;
    logic free_hit;
    logic scan_found;
    logic scan_last;
    logic sweep_last;
  } dp_status_t;

endpackage

// ----- src/bffa_if.sv -----
`timescale 1ns / 1ps

interface bffa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [bffa_pkg::SizeW-1:0]  request_size;
  logic [bffa_pkg::AddrW-1:0]  address;

  modport source (output valid, output action, output request_size, output address,
                  input ready);
  modport sink   (input valid, input action, input request_size, input address,
                  output ready);
endinterface

interface bffa_out_if;
  logic                          valid;
  logic                          ready;
  logic [bffa_pkg::StatusW-1:0]  status;
  logic [bffa_pkg::AddrW-1:0]    result_address;
  logic [bffa_pkg::UsedW-1:0]    used_bytes;
  logic [bffa_pkg::SizeW-1:0]    free_bytes;

  modport source (output valid, output status, output result_address, output used_bytes,
                  output free_bytes, input ready);
  modport sink   (input valid, input status, input result_address, input used_bytes,
                  input free_bytes, output ready);
endinterface

// ----- src/bffa_dp.sv -----
`timescale 1ns / 1ps

module bffa_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bffa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bffa_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_action_i,
  input  logic [bffa_pkg::SizeW-1:0]      in_size_i,
  input  logic [bffa_pkg::AddrW-1:0]      in_address_i,
  input  bffa_pkg::ctl_cmd_t              cmd_i,
  output bffa_pkg::dp_status_t            stat_o,
  output logic [bffa_pkg::StatusW-1:0]    out_status_o,
  output logic [bffa_pkg::AddrW-1:0]      out_address_o,
  output logic [bffa_pkg::UsedW-1:0]      out_used_o,
  output logic [bffa_pkg::SizeW-1:0]      out_free_o
);

  localparam int unsigned OffBlkW = bffa_pkg::AddrW - bffa_pkg::BlockShift;

  // Configuration and pool state
  logic [bffa_pkg::AddrW-1:0]     base_q;
  logic [bffa_pkg::SizeW-1:0]     total_q;
  logic [bffa_pkg::NumBlocks-1:0] map_q;
  logic [bffa_pkg::NumBlocks-1:0] run_valid_q;
  logic [bffa_pkg::UsedW-1:0]     used_q;
  logic [bffa_pkg::RunW-1:0]      run_len_mem [bffa_pkg::NumBlocks];
  logic [bffa_pkg::RunW-1:0]      rd_len_q;

  // Current item
  logic                           action_q;
  logic [bffa_pkg::RunW-1:0]      need_q;
  logic                           need_bad_q;
  logic [bffa_pkg::AddrW-1:0]     addr_q;
  logic [bffa_pkg::IdxW-1:0]      idx_q;
  logic [bffa_pkg::RunW-1:0]      run_q;
  logic [bffa_pkg::IdxW-1:0]      ptr_q;
  logic [bffa_pkg::RunW-1:0]      cnt_q;
  bffa_pkg::status_e              res_status_q;
  logic [bffa_pkg::AddrW-1:0]     res_addr_q;

  // Output word
  bffa_pkg::status_e              out_status_q;
  logic [bffa_pkg::AddrW-1:0]     out_addr_q;
  logic [bffa_pkg::UsedW-1:0]     out_used_q;
  logic [bffa_pkg::SizeW-1:0]     out_free_q;

  logic [bffa_pkg::SizeW:0]       size_round;
  logic [bffa_pkg::NeedW-1:0]     need_full;
  logic [bffa_pkg::AddrW-1:0]     off;
  logic [OffBlkW-1:0]             off_blk;
  logic [bffa_pkg::IdxW-1:0]      free_idx;
  logic                           free_hit;
  logic                           scan_free;
  logic [bffa_pkg::RunW-1:0]      run_inc;
  logic                           scan_found;
  logic [bffa_pkg::IdxW-1:0]      scan_start;
  logic                           sweep_set;
  logic [bffa_pkg::UsedW-1:0]     used_sub;
  logic [bffa_pkg::SizeW-1:0]     used_ext;
  logic [bffa_pkg::SizeW-1:0]     free_bytes;

  // Round the byte count up to whole blocks
  assign size_round = (bffa_pkg::SizeW+1)'(in_size_i)
                    + (bffa_pkg::SizeW+1)'(bffa_pkg::BlockBytes - 1);
  assign need_full  = size_round[bffa_pkg::SizeW:bffa_pkg::BlockShift];

  // A free hits only a live run start at an exact block offset from the base
  assign off      = addr_q - base_q;
  assign off_blk  = off[bffa_pkg::AddrW-1:bffa_pkg::BlockShift];
  assign free_idx = off_blk[bffa_pkg::IdxW-1:0];
  assign free_hit = (off[bffa_pkg::BlockShift-1:0] == '0)
                 && (off_blk < OffBlkW'(bffa_pkg::NumBlocks))
                 && run_valid_q[free_idx];

  // First-fit scan: count free blocks in a row, stop when the count reaches need
  assign scan_free  = !map_q[idx_q];
  assign run_inc    = run_q + bffa_pkg::RunW'(1);
  assign scan_found = scan_free && (run_inc == need_q);
  assign scan_start = bffa_pkg::IdxW'(bffa_pkg::RunW'(idx_q) + bffa_pkg::RunW'(1) - need_q);

  assign sweep_set  = (action_q == bffa_pkg::ACTION_ALLOC);
  assign used_sub   = (used_q >= bffa_pkg::UsedW'(bffa_pkg::BlockBytes))
                    ? used_q - bffa_pkg::UsedW'(bffa_pkg::BlockBytes) : '0;
  assign used_ext   = bffa_pkg::SizeW'(used_q);
  assign free_bytes = (total_q > used_ext) ? total_q - used_ext : '0;

  assign stat_o.alloc      = (action_q == bffa_pkg::ACTION_ALLOC);
  assign stat_o.need_bad   = need_bad_q;
  assign stat_o.free_hit   = free_hit;
  assign stat_o.scan_found = scan_found;
  assign stat_o.scan_last  = (idx_q == bffa_pkg::IdxW'(bffa_pkg::NumBlocks - 1));
  assign stat_o.sweep_last = (cnt_q == bffa_pkg::RunW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      total_q     <= '0;
      map_q       <= '0;
      run_valid_q <= '0;
      used_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bffa_pkg::CFG_BASE_ADDRESS) begin
          base_q <= cfg_data_i[bffa_pkg::AddrW-1:0];
        end else if (cfg_idx_i == bffa_pkg::CFG_TOTAL_SIZE) begin
          total_q <= cfg_data_i[bffa_pkg::SizeW-1:0];
        end
      end
      if (cmd_i.scan_step && scan_found) begin
        run_valid_q[scan_start] <= 1'b1;
        used_q <= used_q + (bffa_pkg::UsedW'(need_q) << bffa_pkg::BlockShift);
      end
      if (cmd_i.free_read) begin
        run_valid_q[ptr_q] <= 1'b0;
      end
      if (cmd_i.sweep_step) begin
        map_q[ptr_q] <= sweep_set;
        if (!sweep_set) begin
          used_q <= used_sub;
        end
      end
    end
  end

  // Run-length store; an entry is meaningful only while its valid bit is set
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && scan_found) begin
      run_len_mem[scan_start] <= need_q;
    end
    rd_len_q <= run_len_mem[free_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q   <= in_action_i;
      need_q     <= bffa_pkg::RunW'(need_full);
      need_bad_q <= (need_full == '0) || (need_full > bffa_pkg::NeedW'(bffa_pkg::NumBlocks));
      addr_q     <= in_address_i;
    end
    if (cmd_i.check) begin
      idx_q      <= '0;
      run_q      <= '0;
      ptr_q      <= free_idx;
      res_addr_q <= '0;
      // an allocate presets failure; a found run overwrites it
      if (action_q == bffa_pkg::ACTION_ALLOC) begin
        res_status_q <= bffa_pkg::STATUS_NO_FIT;
      end else begin
        res_status_q <= free_hit ? bffa_pkg::STATUS_OK : bffa_pkg::STATUS_NOT_FOUND;
      end
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + bffa_pkg::IdxW'(1);
      run_q <= scan_free ? run_inc : '0;
      if (scan_found) begin
        ptr_q        <= scan_start;
        cnt_q        <= need_q;
        res_status_q <= bffa_pkg::STATUS_OK;
        res_addr_q   <= base_q + (bffa_pkg::AddrW'(scan_start) << bffa_pkg::BlockShift);
      end
    end
    if (cmd_i.free_read) begin
      cnt_q <= rd_len_q;
    end
    if (cmd_i.sweep_step) begin
      ptr_q <= ptr_q + bffa_pkg::IdxW'(1);
      cnt_q <= cnt_q - bffa_pkg::RunW'(1);
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_used_q   <= used_q;
      out_free_q   <= free_bytes;
    end
  end

  assign out_status_o  = out_status_q;
  assign out_address_o = out_addr_q;
  assign out_used_o    = out_used_q;
  assign out_free_o    = out_free_q;

  // Byte count tracks the reservation map between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check |-> (32'(used_q) == (32'($countones(map_q)) << bffa_pkg::BlockShift)))
    else $error("used byte count out of step with reservation map");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |-> (cnt_q != '0))
    else $error("sweep ran past end of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_read |-> ((rd_len_q != '0)
      && (32'(ptr_q) + 32'(rd_len_q) <= 32'(bffa_pkg::NumBlocks))))
    else $error("live run record is empty or overruns the pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && scan_found) |-> !run_valid_q[scan_start])
    else $error("new run starts on a live run");

endmodule

// ----- src/bffa_ctrl.sv -----
`timescale 1ns / 1ps

module bffa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  bffa_pkg::dp_status_t  stat_i,
  output bffa_pkg::ctl_cmd_t    cmd_o
);

  bffa_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bffa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bffa_pkg::ST_CHECK;
      end
      bffa_pkg::ST_CHECK: begin
        if (stat_i.alloc) begin
          state_d = stat_i.need_bad ? bffa_pkg::ST_REPORT : bffa_pkg::ST_SCAN;
        end else begin
          state_d = stat_i.free_hit ? bffa_pkg::ST_FREE_RD : bffa_pkg::ST_REPORT;
        end
      end
      bffa_pkg::ST_SCAN: begin
        priority if (stat_i.scan_found) begin
          state_d = bffa_pkg::ST_SWEEP;
        end else if (stat_i.scan_last) begin
          state_d = bffa_pkg::ST_REPORT;
        end
      end
      bffa_pkg::ST_FREE_RD: begin
        state_d = bffa_pkg::ST_SWEEP;
      end
      bffa_pkg::ST_SWEEP: begin
        if (stat_i.sweep_last) state_d = bffa_pkg::ST_REPORT;
      end
      bffa_pkg::ST_REPORT: begin
        if (out_free) state_d = bffa_pkg::ST_IDLE;
      end
      default: state_d = bffa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    unique case (state_q)
      bffa_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      bffa_pkg::ST_CHECK:   cmd_o.check      = 1'b1;
      bffa_pkg::ST_SCAN:    cmd_o.scan_step  = 1'b1;
      bffa_pkg::ST_FREE_RD: cmd_o.free_read  = 1'b1;
      bffa_pkg::ST_SWEEP:   cmd_o.sweep_step = 1'b1;
      bffa_pkg::ST_REPORT:  cmd_o.load_out   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bffa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/bitmap_first_fit_block_allocator_top.sv -----
`timescale 1ns / 1ps
// An allocate is checked, scanned from block 0 to the end of the first fitting run and
//   swept over that run; a failed one scans the whole map, a zero or oversize one goes
//   straight to the report; a free reads its run record, then sweeps or reports a miss.
// Throughput: one word at a time, set by the one-block-per-cycle bitmap scan and sweep.
// Reset (async, active low) frees every block, clears run records and counts at once.
module bitmap_first_fit_block_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bffa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bffa_pkg::CfgDataW-1:0]  cfg_data_i,
  bffa_in_if.sink                        in_i,
  bffa_out_if.source                     out_o
);

  bffa_pkg::ctl_cmd_t   cmd;
  bffa_pkg::dp_status_t stat;

  // Controller: sequences check, scan, run-record read, block sweep and report.
  // Take a new word only when idle; the output register holds the last result
  // while the next word is already being worked on.
  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: reservation bitmap, live-run bits, run-length store, byte counters,
  // configuration registers and the output register.
  bffa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_action_i   (in_i.action),
    .in_size_i     (in_i.request_size),
    .in_address_i  (in_i.address),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_status_o  (out_o.status),
    .out_address_o (out_o.result_address),
    .out_used_o    (out_o.used_bytes),
    .out_free_o    (out_o.free_bytes)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // One reply word as the allocator reports it
  typedef struct packed {
    bffa_pkg::status_e                status;
    logic [bffa_pkg::AddrW-1:0]       addr;
    logic [bffa_pkg::UsedW-1:0]       used;
    logic [bffa_pkg::SizeW-1:0]       free_b;
  } reply_t;

  // One line of the directed plan: a register write or a request word. The reply
  // is typed in only where it is obvious; those replies all carry address 0.
  typedef struct packed {
    logic                             is_cfg;
    logic [bffa_pkg::CfgIdxW-1:0]     idx;
    logic [bffa_pkg::AddrW-1:0]       data;    // register value, or the address of a request
    logic                             action;
    logic [bffa_pkg::SizeW-1:0]       size;
    logic                             typed;
    bffa_pkg::status_e                st;
    logic [bffa_pkg::UsedW-1:0]       used;
    logic [bffa_pkg::SizeW-1:0]       free_b;
  } plan_row_t;

  // An index that maps to no register; writes to it must change nothing
  localparam logic [bffa_pkg::CfgIdxW-1:0] CFG_UNMAPPED = bffa_pkg::CfgIdxW'(8'hFF);

  localparam int          PlanLen       = 26;
  localparam int          NumPhases     = 8;
  localparam int          ItemsPerPhase = 225;
  localparam int unsigned CycleLimit    = 4_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                          cfg_we_i;
  logic [bffa_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bffa_pkg::CfgDataW-1:0] cfg_data_i;

  bffa_in_if  req_if ();
  bffa_out_if rsp_if ();

  bitmap_first_fit_block_allocator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // 20 ns period
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pool shadow: reservation bits, run length per start block, bytes held and
  // the two registers. Updated in acceptance order, one request word at a time.
  // ---------------------------------------------------------------------------
  bit                         blk_taken [bffa_pkg::NumBlocks];
  int unsigned                run_blocks [bffa_pkg::NumBlocks];
  longint unsigned            bytes_held;
  logic [bffa_pkg::AddrW-1:0] pool_base;
  logic [bffa_pkg::SizeW-1:0] pool_total;

  reply_t      replies_due [$];
  plan_row_t   plan [PlanLen];
  int          idle_pct;
  int          stall_pct;
  int          errors = 0;
  int          words_sent;
  int          runs_reserved;
  int          runs_released;
  int          refused;
  int          unknown_frees;
  int unsigned cycle_count = 0;

  function automatic logic [bffa_pkg::AddrW-1:0] block_base(int idx);
    return pool_base + bffa_pkg::AddrW'(idx * bffa_pkg::BlockBytes);
  endfunction

  function automatic logic [bffa_pkg::AddrW-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Apply one request to the shadow pool and return the reply it must produce
  function automatic reply_t serve_request(logic act, logic [bffa_pkg::SizeW-1:0] size,
                                           logic [bffa_pkg::AddrW-1:0] addr);
    reply_t          r;
    longint unsigned need;
    int unsigned     free_run;
    int              start;
    r = '{bffa_pkg::STATUS_NO_FIT, '0, '0, '0};
    start = -1;
    if (act == bffa_pkg::ACTION_ALLOC) begin
      // Round up to whole blocks; a zero or oversize need never scans
      need = ({32'd0, size} + 64'(bffa_pkg::BlockBytes) - 64'd1)
           / 64'(bffa_pkg::BlockBytes);
      if (need != 0 && need <= bffa_pkg::NumBlocks) begin
        free_run = 0;
        for (int i = 0; i < bffa_pkg::NumBlocks && start < 0; i++) begin
          free_run = blk_taken[i] ? 0 : free_run + 1;
          if (free_run == need) start = i - int'(need) + 1;
        end
      end
      if (start >= 0) begin
        for (int j = start; j < start + int'(need); j++) blk_taken[j] = 1'b1;
        run_blocks[start] = int'(need);
        bytes_held += need * bffa_pkg::BlockBytes;
        r.status = bffa_pkg::STATUS_OK;
        r.addr   = block_base(start);
        runs_reserved++;
      end else begin
        refused++;
      end
    end else begin
      // Look runs up at the current base, so a moved base hides old addresses
      for (int i = 0; i < bffa_pkg::NumBlocks && start < 0; i++)
        if (run_blocks[i] != 0 && block_base(i) == addr) start = i;
      if (start < 0) begin
        r.status = bffa_pkg::STATUS_NOT_FOUND;
        unknown_frees++;
      end else begin
        for (int j = 0; j < run_blocks[start] && start + j < bffa_pkg::NumBlocks; j++) begin
          blk_taken[start + j] = 1'b0;
          bytes_held = (bytes_held >= bffa_pkg::BlockBytes)
                     ? bytes_held - bffa_pkg::BlockBytes : 0;
        end
        run_blocks[start] = 0;
        r.status = bffa_pkg::STATUS_OK;
        runs_released++;
      end
    end
    r.used   = bffa_pkg::UsedW'(bytes_held);
    r.free_b = (bytes_held >= pool_total) ? '0 : bffa_pkg::SizeW'(pool_total - bytes_held);
    return r;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Write one register: pulse the enable, then update the shadow base or total
  task automatic write_reg(logic [bffa_pkg::CfgIdxW-1:0] idx,
                           logic [bffa_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bffa_pkg::CFG_BASE_ADDRESS) pool_base = data;
    else if (idx == bffa_pkg::CFG_TOTAL_SIZE) pool_total = data[bffa_pkg::SizeW-1:0];
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every owed reply word has come back
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one request word, wait for acceptance, then record the owed reply
  task automatic send_request(logic act, logic [bffa_pkg::SizeW-1:0] size,
                              logic [bffa_pkg::AddrW-1:0] addr,
                              logic use_typed, reply_t typed_reply);
    reply_t want;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.request_size <= size;
    req_if.address      <= addr;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    want = serve_request(act, size, addr);
    replies_due.push_back(use_typed ? typed_reply : want);
    words_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: stall at the phase's rate and compare every accepted word with
  // the oldest owed reply, field by field.
  // ---------------------------------------------------------------------------
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        flag_error($sformatf("reply word with none owed: status %0d addr %h",
                             rsp_if.status, rsp_if.result_address));
      end else begin
        want = replies_due.pop_front();
        if (rsp_if.status !== want.status)
          flag_error($sformatf("status %0d, want %0d", rsp_if.status, want.status));
        if (rsp_if.result_address !== want.addr)
          flag_error($sformatf("result_address %h, want %h", rsp_if.result_address,
                               want.addr));
        if (rsp_if.used_bytes !== want.used)
          flag_error($sformatf("used_bytes %0d, want %0d", rsp_if.used_bytes, want.used));
        if (rsp_if.free_bytes !== want.free_b)
          flag_error($sformatf("free_bytes %0d, want %0d", rsp_if.free_bytes,
                               want.free_b));
      end
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d reply words owed",
               cycle_count, replies_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    reply_t                     typed_reply;
    logic                       act;
    logic [bffa_pkg::SizeW-1:0] s;
    logic [bffa_pkg::AddrW-1:0] a;
    int                         r;
    int                         live [$];

    words_sent = 0;
    runs_reserved = 0;
    runs_released = 0;
    refused = 0;
    unknown_frees = 0;
    bytes_held = 0;
    pool_base = '0;
    pool_total = '0;
    idle_pct = 0;
    stall_pct = 0;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_UNMAPPED;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= bffa_pkg::ACTION_ALLOC;
    req_if.request_size <= '0;
    req_if.address      <= '0;

    // Directed plan. The first base puts block 2 on the 48-bit wrap, the small
    // total drives free bytes into saturation, and the later base move hides the
    // old run addresses.
    plan = '{
      // empty pool: zero size, oversize, unknown address
      '{1'b0, CFG_UNMAPPED, 48'hFFFFFFFFFFFF, bffa_pkg::ACTION_ALLOC, 32'h0, 1'b1,
        bffa_pkg::STATUS_NO_FIT, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'hFFFFFFFF, 1'b1,
        bffa_pkg::STATUS_NO_FIT, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_FREE, 32'hFFFFFFFF, 1'b1,
        bffa_pkg::STATUS_NOT_FOUND, 21'd0, 32'd0},
      '{1'b1, bffa_pkg::CFG_BASE_ADDRESS, 48'hFFFFFFFFE000, bffa_pkg::ACTION_ALLOC, 32'h0,
        1'b0, bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b1, bffa_pkg::CFG_TOTAL_SIZE, 48'h3000, bffa_pkg::ACTION_ALLOC, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b1, CFG_UNMAPPED, 48'hFFFFFFFFFFFF, bffa_pkg::ACTION_ALLOC, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      // fill: one byte, one block, just over a block (wraps), too many, the rest, one byte more
      '{1'b0, CFG_UNMAPPED, 48'hFFFFFFFFFFFF, bffa_pkg::ACTION_ALLOC, 32'h1, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h1000, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h1001, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h100000, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'hFC000, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h1, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      // free a run twice, free a run body, refill the hole
      '{1'b0, CFG_UNMAPPED, 48'hFFFFFFFFF000, bffa_pkg::ACTION_FREE, 32'hFFFFFFFF, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'hFFFFFFFFF000, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h1000, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h1000, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      // move the base, widen the total (upper data bits must be dropped)
      '{1'b1, bffa_pkg::CFG_BASE_ADDRESS, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b1, bffa_pkg::CFG_TOTAL_SIZE, 48'hFFFFFFFFFFFF, bffa_pkg::ACTION_ALLOC, 32'h0,
        1'b0, bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'hFFFFFFFFE000, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h2000, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h1000, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h4000, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      // whole pool in one run, release it, then a zero size on the empty pool
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_ALLOC, 32'h100000, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h0, bffa_pkg::ACTION_FREE, 32'h0, 1'b0,
        bffa_pkg::STATUS_OK, 21'd0, 32'd0},
      '{1'b0, CFG_UNMAPPED, 48'h5A5A5A5A5A5A, bffa_pkg::ACTION_ALLOC, 32'h0, 1'b1,
        bffa_pkg::STATUS_NO_FIT, 21'd0, 32'hFFFFFFFF}
    };

    // Hold reset, then release it; the pool comes up empty with both registers zero
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain_replies();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        typed_reply = '{plan[k].st, '0, plan[k].used, plan[k].free_b};
        send_request(plan[k].action, plan[k].size, plan[k].data, plan[k].typed,
                     typed_reply);
      end
    end

    // Random traffic in phases. Each phase drains, sets new registers and picks
    // an idle/stall mix; most words are small allocations and frees of live runs,
    // the rest larger, boundary, zero or huge sizes and frees of stray addresses.
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_replies();
      case (phase)
        0: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, '0);
          write_reg(bffa_pkg::CFG_TOTAL_SIZE,
                    bffa_pkg::CfgDataW'(bffa_pkg::NumBlocks * bffa_pkg::BlockBytes));
        end
        1: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, '1);
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, 48'hFFFFFFFF);
        end
        2: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, rand48());
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, '0);
        end
        3: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, rand48());
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, bffa_pkg::CfgDataW'(
                    $urandom_range(0, 2 * bffa_pkg::NumBlocks * bffa_pkg::BlockBytes)));
        end
        4: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, '0);
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, rand48());
        end
        5: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, 48'hFFFFFFFFF000);
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, 48'h80000);
          write_reg(CFG_UNMAPPED, rand48());
        end
        6: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, rand48());
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, rand48());
        end
        default: begin
          write_reg(bffa_pkg::CFG_BASE_ADDRESS, 48'h800000000000);
          write_reg(bffa_pkg::CFG_TOTAL_SIZE, 48'h7FFFFFFF);
          write_reg(CFG_UNMAPPED, '0);
        end
      endcase

      // No idling, sender idle 70 %, receiver stalling 70 %, both at 9 %
      case (phase % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Now and then hold off until the allocator has answered everything
        if ((phase == 1 && n == 100) || $urandom_range(149) == 0) drain_replies();
        r   = $urandom_range(99);
        act = bffa_pkg::ACTION_ALLOC;
        s   = $urandom;
        a   = rand48();
        if (r < 35) begin
          s = $urandom_range(1, 6 * bffa_pkg::BlockBytes);
        end else if (r < 42) begin
          s = $urandom_range(1, bffa_pkg::NumBlocks * bffa_pkg::BlockBytes);
        end else if (r < 47) begin
          // one below, on and one above a block boundary
          s = $urandom_range(1, bffa_pkg::NumBlocks) * bffa_pkg::BlockBytes
            + $urandom_range(2) - 1;
        end else if (r < 85) begin
          act = bffa_pkg::ACTION_FREE;
          live.delete();
          for (int i = 0; i < bffa_pkg::NumBlocks; i++)
            if (run_blocks[i] != 0) live.push_back(i);
          if (live.size() != 0) a = block_base(live[$urandom_range(live.size() - 1)]);
        end else if (r < 90) begin
          // a random address or any block boundary: a run start, a run body or nothing at all
          act = bffa_pkg::ACTION_FREE;
          if ($urandom_range(1) == 1) a = block_base($urandom_range(bffa_pkg::NumBlocks - 1));
        end else if (r < 94) begin
          s = '0;
        end
        // otherwise keep the full-width random size, nearly always too large
        send_request(act, s, a, 1'b0, typed_reply);
      end
    end

    // Let the last replies come home, then allow for a full scan and sweep
    drain_replies();
    repeat (2 * bffa_pkg::NumBlocks + 16) @(posedge clk_i);

    $display("Sent %0d request words through %0d register settings and four idle/stall mixes;",
             words_sent, NumPhases + 2);
    $display("%0d runs reserved, %0d released, %0d allocations refused, %0d unknown frees.",
             runs_reserved, runs_released, refused, unknown_frees);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
